FILE: design/brs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// types, codes and sizes shared by the branch reservation station
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned SLOTS = 4;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_WAKEUP = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_FLUSH  = 2'd3;

  localparam logic [2:0] OP_BEQ  = 3'd0;
  localparam logic [2:0] OP_BNE  = 3'd1;
  localparam logic [2:0] OP_J    = 3'd2;
  localparam logic [2:0] OP_JR   = 3'd3;
  localparam logic [2:0] OP_HALT = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] operand_c;
    logic               a_ready;
    logic               b_ready;
    logic [5:0]         rob_tag;
    logic [5:0]         wake_tag;
    logic signed [31:0] wake_value;
  } brs_req_t;

  typedef struct packed {
    logic               insert_accepted;
    logic               space_free;
    logic               dispatch_valid;
    logic [2:0]         dispatch_opcode;
    logic signed [31:0] dispatch_a;
    logic signed [31:0] dispatch_b;
    logic signed [31:0] dispatch_c;
    logic [5:0]         dispatch_rob;
  } brs_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } brs_pick_t;

endpackage
`default_nettype wire

FILE: design/brs_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pick
// rotating priority pick of the first ready slot from the scan pointer
// ----------------------------------------------------------------------------
module brs_pick (
  input  logic [brs_pkg::SLOTS-1:0] ready_i,
  input  logic [brs_pkg::IDX_W-1:0] start_i,
  output brs_pkg::brs_pick_t        pick_o
);
  import brs_pkg::*;

  always_comb begin
    logic [IDX_W:0] pos;
    pick_o = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      pos = {1'b0, start_i} + (IDX_W + 1)'(k);
      if (pos >= (IDX_W + 1)'(SLOTS)) begin
        pos = pos - (IDX_W + 1)'(SLOTS);
      end
      if (ready_i[pos[IDX_W-1:0]]) begin
        pick_o.hit = 1'b1;
        pick_o.idx = pos[IDX_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/brs_slots.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brs_slots
// slot storage with insert, wakeup, dispatch and flush in one pass
// ----------------------------------------------------------------------------
module brs_slots (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_vld_i,
  input  brs_pkg::brs_req_t req_i,
  output brs_pkg::brs_rsp_t rsp_o
);
  import brs_pkg::*;

  logic [SLOTS-1:0] busy_q, busy_d, ardy_q, ardy_d, brdy_q, brdy_d;
  logic [SLOTS-1:0] cond, ready;
  logic [2:0]       op_q  [SLOTS];
  logic [2:0]       op_d  [SLOTS];
  logic [31:0]      a_q   [SLOTS];
  logic [31:0]      a_d   [SLOTS];
  logic [31:0]      b_q   [SLOTS];
  logic [31:0]      b_d   [SLOTS];
  logic [31:0]      c_q   [SLOTS];
  logic [31:0]      c_d   [SLOTS];
  logic [5:0]       rob_q [SLOTS];
  logic [5:0]       rob_d [SLOTS];
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] free_idx;
  logic             free_any;
  logic             op_ok;
  logic [31:0]      wtag_ext;
  brs_pick_t        pick;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cond[i]  = (op_q[i] == OP_BEQ) || (op_q[i] == OP_BNE);
      ready[i] = busy_q[i] && (cond[i] ? (ardy_q[i] && brdy_q[i]) : 1'b1);
    end
  end

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  brs_pick u_pick (
    .ready_i (ready),
    .start_i (ptr_q),
    .pick_o  (pick)
  );

  assign op_ok    = (req_i.opcode <= OP_HALT);
  assign wtag_ext = {26'd0, req_i.wake_tag};

  always_comb begin
    busy_d = busy_q;
    ardy_d = ardy_q;
    brdy_d = brdy_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    rob_d  = rob_q;
    ptr_d  = ptr_q;
    rsp_o  = '0;
    if (req_vld_i) begin
      case (req_i.kind)
        KIND_INSERT: begin
          if (op_ok && free_any) begin
            busy_d[free_idx] = 1'b1;
            ardy_d[free_idx] = req_i.a_ready;
            brdy_d[free_idx] = req_i.b_ready;
            op_d[free_idx]   = req_i.opcode;
            a_d[free_idx]    = req_i.operand_a;
            b_d[free_idx]    = req_i.operand_b;
            c_d[free_idx]    = req_i.operand_c;
            rob_d[free_idx]  = req_i.rob_tag;
            rsp_o.insert_accepted = 1'b1;
          end
        end
        KIND_WAKEUP: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (busy_q[i] && cond[i]) begin
              if (!ardy_q[i] && (a_q[i] == wtag_ext)) begin
                a_d[i]    = req_i.wake_value;
                ardy_d[i] = 1'b1;
              end
              if (!brdy_q[i] && (b_q[i] == wtag_ext)) begin
                b_d[i]    = req_i.wake_value;
                brdy_d[i] = 1'b1;
              end
            end
          end
        end
        KIND_TICK: begin
          if (pick.hit) begin
            rsp_o.dispatch_valid  = 1'b1;
            rsp_o.dispatch_opcode = op_q[pick.idx];
            rsp_o.dispatch_a      = a_q[pick.idx];
            rsp_o.dispatch_b      = b_q[pick.idx];
            rsp_o.dispatch_c      = c_q[pick.idx];
            rsp_o.dispatch_rob    = rob_q[pick.idx];
            busy_d[pick.idx]      = 1'b0;
            ardy_d[pick.idx]      = 1'b0;
            brdy_d[pick.idx]      = 1'b0;
          end
          if (ptr_q == IDX_W'(SLOTS - 1)) begin
            ptr_d = '0;
          end else begin
            ptr_d = ptr_q + IDX_W'(1);
          end
        end
        KIND_FLUSH: begin
          busy_d = '0;
          ardy_d = '0;
          brdy_d = '0;
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
    rsp_o.space_free = ~&busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      ardy_q <= '0;
      brdy_q <= '0;
      ptr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ardy_q <= ardy_d;
      brdy_q <= brdy_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    rob_q <= rob_d;
  end

endmodule
`default_nettype wire

FILE: design/branch_reservation_station_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// branch_reservation_station_unit
// branch reservation station with rotating dispatch pick
// ----------------------------------------------------------------------------
// A request (insert, wakeup, tick or flush) is taken whenever start is high;
// busy stays low, so one request can be sent every cycle. Each request gives
// exactly one result, shown on rsp_o with rsp_valid_o high for one cycle: the
// request is registered, then all slots are updated in one pass and the result
// is registered. Results in order. The receiver cannot hold a result off, so
// it must take each one when strobed.

module branch_reservation_station_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  brs_pkg::brs_req_t req_i,
  output logic              rsp_valid_o,
  output brs_pkg::brs_rsp_t rsp_o
);
  import brs_pkg::*;

  logic     req_vld_q;
  brs_req_t req_q;
  logic     rsp_vld_q;
  brs_rsp_t rsp_q;
  brs_rsp_t rsp_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
    rsp_q <= rsp_d;
  end

  brs_slots u_slots (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_vld_i (req_vld_q),
    .req_i     (req_q),
    .rsp_o     (rsp_d)
  );

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  a_rsp_follows_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> $past(req_vld_q))
    else $error("result without request");

  a_dispatch_on_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_q.dispatch_valid) |-> ($past(req_q.kind) == KIND_TICK))
    else $error("dispatch outside tick");

  a_accept_on_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_q.insert_accepted) |-> ($past(req_q.kind) == KIND_INSERT))
    else $error("insert accepted outside insert");

  a_one_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> $onehot0({rsp_q.insert_accepted, rsp_q.dispatch_valid}))
    else $error("insert and dispatch together");

endmodule
`default_nettype wire
